### rtl/core/lprr_pkg.sv
`timescale 1ns / 1ps

package lprr_pkg;

    localparam int RING_DEPTH_DEF = 1024;
    localparam int CFG_W          = 11;
    localparam int SIZE_RESET     = 1024;
    localparam int OP_W           = 2;
    localparam int BYTE_W         = 8;
    localparam int STATUS_W       = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_HDR  = 2'd0,
        OP_PUSH_BYTE = 2'd1,
        OP_POP_HDR   = 2'd2,
        OP_POP_BYTE  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_NO_ROOM = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_CORRUPT = 3'd3,
        ST_NO_OPEN = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

endpackage

### rtl/core/lprr_in_if.sv
`timescale 1ns / 1ps

interface lprr_in_if import lprr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] value;

    modport source (output valid, operation, value, input ready);
    modport sink (input valid, operation, value, output ready);
endinterface

### rtl/core/lprr_out_if.sv
`timescale 1ns / 1ps

interface lprr_out_if import lprr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   out_value;
    logic                last;

    modport source (output valid, status, out_value, last, input ready);
    modport sink (input valid, status, out_value, last, output ready);
endinterface

### rtl/core/lprr_ram.sv
`timescale 1ns / 1ps

module lprr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/core/length_prefixed_record_ring.sv
`timescale 1ns / 1ps

// Byte ring of RING_DEPTH entries holding length-prefixed records in one single-port
// memory. Each command word returns exactly one response word. Push header, push byte
// and every refused command answer the cycle after acceptance, so with the response
// side ready such commands flow at one per cycle; pop header and pop byte read the
// memory and answer from the read data in S_READ, accepting no command meanwhile. A new
// command is taken once the pending response is gone or leaves in the same cycle.
// A write of ring_size (clamped to 2..RING_DEPTH) empties the ring and drops any open
// record; write it only while no command is in flight. Memory contents are not cleared
// at reset; there is no clearing pass.
module length_prefixed_record_ring import lprr_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    lprr_in_if.sink          cmd,
    lprr_out_if.source       rsp
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int SW = $clog2(RING_DEPTH + 1);
    localparam int AW = SW + 1;
    localparam int CW = (AW > BYTE_W + 1) ? AW : BYTE_W + 1;
    localparam int MW = ((SW > CFG_W) ? SW : CFG_W) + 1;
    localparam int SIZE_INIT = (RING_DEPTH < SIZE_RESET) ? RING_DEPTH : SIZE_RESET;

    state_t              state_reg, state_next;
    logic [SW-1:0]       size_reg, size_next;
    logic [PW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [BYTE_W-1:0]   push_left_reg, push_left_next;
    logic [BYTE_W-1:0]   pop_left_reg, pop_left_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [BYTE_W-1:0]   val_reg, val_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [BYTE_W-1:0]   out_value_reg, out_value_next;
    logic                out_last_reg, out_last_next;

    logic                accept;
    logic                ram_we;
    logic [PW-1:0]       ram_addr;
    logic [BYTE_W-1:0]   ram_wdata;
    logic [BYTE_W-1:0]   ram_rdata;

    logic [AW-1:0]       size_ext, rp_ext, wp_ext, rp_inc, wp_inc;
    logic [AW-1:0]       free_bytes, stored_bytes;
    logic [PW-1:0]       rp_adv, wp_adv;
    logic [MW-1:0]       cfg_ext, size_cfg;

    lprr_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(RING_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign cmd.ready     = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept        = cmd.valid && cmd.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.out_value = out_value_reg;
    assign rsp.last      = out_last_reg;

    // pointer arithmetic, pointers always below the size in use
    assign size_ext = AW'(size_reg);
    assign rp_ext   = AW'(rd_ptr_reg);
    assign wp_ext   = AW'(wr_ptr_reg);
    assign rp_inc   = rp_ext + AW'(1);
    assign wp_inc   = wp_ext + AW'(1);
    assign rp_adv   = (rp_inc >= size_ext) ? '0 : rp_inc[PW-1:0];
    assign wp_adv   = (wp_inc >= size_ext) ? '0 : wp_inc[PW-1:0];

    // one byte of the ring always stays unused
    assign free_bytes   = (rp_ext > wp_ext) ? (rp_ext - wp_ext - AW'(1))
                                            : (rp_ext + size_ext - wp_ext - AW'(1));
    assign stored_bytes = (wp_ext >= rp_ext) ? (wp_ext - rp_ext)
                                             : (wp_ext + size_ext - rp_ext);

    assign cfg_ext  = MW'(cfg_wdata);
    assign size_cfg = (cfg_ext > MW'(RING_DEPTH)) ? MW'(RING_DEPTH) :
                      ((cfg_ext < MW'(2)) ? MW'(2) : cfg_ext);

    always_comb
    begin
        state_next      = state_reg;
        size_next       = size_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        push_left_next  = push_left_reg;
        pop_left_next   = pop_left_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_addr        = wr_ptr_reg;
        ram_wdata       = cmd.value;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = cmd.operation;
                    val_next        = cmd.value;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_value_next  = '0;
                    out_last_next   = 1'b0;
                    case (cmd.operation)
                        OP_PUSH_HDR:
                        begin
                            if (push_left_reg != '0 || CW'(free_bytes) <= CW'(cmd.value))
                            begin
                                out_status_next = ST_NO_ROOM;
                            end
                            else
                            begin
                                ram_we         = 1'b1;
                                wr_ptr_next    = wp_adv;
                                push_left_next = cmd.value;
                                out_last_next  = (cmd.value == '0);
                            end
                        end
                        OP_PUSH_BYTE:
                        begin
                            if (push_left_reg == '0)
                            begin
                                out_status_next = ST_NO_OPEN;
                            end
                            else
                            begin
                                ram_we         = 1'b1;
                                wr_ptr_next    = wp_adv;
                                push_left_next = push_left_reg - BYTE_W'(1);
                                out_last_next  = (push_left_reg == BYTE_W'(1));
                            end
                        end
                        OP_POP_HDR:
                        begin
                            if (pop_left_reg != '0 || rd_ptr_reg == wr_ptr_reg)
                            begin
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ram_addr       = rd_ptr_reg;
                                out_valid_next = 1'b0;
                                state_next     = S_READ;
                            end
                        end
                        OP_POP_BYTE:
                        begin
                            if (pop_left_reg == '0)
                            begin
                                out_status_next = ST_NO_OPEN;
                            end
                            else
                            begin
                                ram_addr       = rd_ptr_reg;
                                out_valid_next = 1'b0;
                                state_next     = S_READ;
                            end
                        end
                        default:
                        begin
                            out_status_next = ST_NO_OPEN;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // read data of the byte at the read pointer is here now
                state_next      = S_IDLE;
                out_valid_next  = 1'b1;
                out_status_next = ST_OK;
                out_value_next  = '0;
                out_last_next   = 1'b0;
                if (op_reg == OP_POP_HDR)
                begin
                    if (ram_rdata > val_reg || ram_rdata == '0 ||
                        CW'(stored_bytes) <= CW'(ram_rdata))
                    begin
                        out_status_next = ST_CORRUPT;
                        rd_ptr_next     = '0;
                        wr_ptr_next     = '0;
                        push_left_next  = '0;
                        pop_left_next   = '0;
                    end
                    else
                    begin
                        rd_ptr_next    = rp_adv;
                        pop_left_next  = ram_rdata;
                        out_value_next = ram_rdata;
                    end
                end
                else
                begin
                    rd_ptr_next    = rp_adv;
                    pop_left_next  = pop_left_reg - BYTE_W'(1);
                    out_value_next = ram_rdata;
                    out_last_next  = (pop_left_reg == BYTE_W'(1));
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // size write flushes the ring
        if (cfg_we)
        begin
            size_next      = size_cfg[SW-1:0];
            rd_ptr_next    = '0;
            wr_ptr_next    = '0;
            push_left_next = '0;
            pop_left_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= SW'(SIZE_INIT);
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            push_left_reg <= '0;
            pop_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            push_left_reg <= push_left_next;
            pop_left_reg  <= pop_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    a_read_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> !out_valid_reg)
        else $error("memory read in progress while a response is still pending");

    a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (out_valid_reg || state_reg == S_READ))
        else $error("accepted command produced neither a response nor a read");

    a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (rp_ext < size_ext) && (wp_ext < size_ext))
        else $error("ring pointer outside the size in use");

    a_read_returns: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("memory read did not complete into a response");

endmodule

### sim/length_prefixed_record_ring_test.sv
`timescale 1ns / 1ps

module length_prefixed_record_ring_test;
    import lprr_pkg::*;

    localparam int QUIET_LIMIT = 400;

    typedef struct packed {
        status_t           status;
        logic [BYTE_W-1:0] out_value;
        logic              last;
    } ring_reply_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    lprr_in_if  cmd ();
    lprr_out_if rsp ();

    length_prefixed_record_ring DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow of the ring as the block should hold it
    logic [BYTE_W-1:0] ring_img [RING_DEPTH_DEF];
    int unsigned       head_idx;
    int unsigned       tail_idx;
    int unsigned       push_owed;
    int unsigned       pop_owed;
    logic [CFG_W-1:0]  size_reg;

    ring_reply_t pending_replies [$];
    int unsigned words_sent;
    int unsigned fail_count;
    int unsigned quiet_cycles;
    int unsigned next_gap;
    bit          cmd_calm;
    bit          rsp_calm;

    function automatic int unsigned span_now();
        if (size_reg < 2)
            return 2;
        if (size_reg > RING_DEPTH_DEF)
            return RING_DEPTH_DEF;
        return 32'(size_reg);
    endfunction

    function automatic int unsigned next_slot(input int unsigned idx, input int unsigned span);
        return (idx + 1 >= span) ? 0 : idx + 1;
    endfunction

    function automatic void clear_ring();
        head_idx  = 0;
        tail_idx  = 0;
        push_owed = 0;
        pop_owed  = 0;
    endfunction

    // occasionally flips into or out of a run with no idle cycles
    function automatic int unsigned draw_gap(inout bit calm);
        if ($urandom_range(0, 24) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic ring_reply_t apply_command(input op_t op, input logic [BYTE_W-1:0] v);
        ring_reply_t       r;
        int unsigned       span;
        int unsigned       room;
        int unsigned       held;
        logic [BYTE_W-1:0] hdr;
        span        = span_now();
        r.status    = ST_OK;
        r.out_value = '0;
        r.last      = 1'b0;
        if (head_idx >= span)
            head_idx = 0;
        if (tail_idx >= span)
            tail_idx = 0;
        case (op)
            OP_PUSH_HDR:
            begin
                // one slot always stays empty
                room = (head_idx + span - tail_idx - 1) % span;
                if (push_owed != 0 || room <= 32'(v))
                    r.status = ST_NO_ROOM;
                else
                begin
                    ring_img[tail_idx] = v;
                    tail_idx  = next_slot(tail_idx, span);
                    push_owed = 32'(v);
                    r.last    = (v == 0);
                end
            end
            OP_PUSH_BYTE:
            begin
                if (push_owed == 0)
                    r.status = ST_NO_OPEN;
                else
                begin
                    ring_img[tail_idx] = v;
                    tail_idx  = next_slot(tail_idx, span);
                    push_owed = push_owed - 1;
                    r.last    = (push_owed == 0);
                end
            end
            OP_POP_HDR:
            begin
                if (pop_owed != 0 || head_idx == tail_idx)
                    r.status = ST_EMPTY;
                else
                begin
                    hdr  = ring_img[head_idx];
                    held = (tail_idx + span - head_idx) % span;
                    if (hdr > v || hdr == 0 || held < 32'(hdr) + 1)
                    begin
                        clear_ring();
                        r.status = ST_CORRUPT;
                    end
                    else
                    begin
                        head_idx    = next_slot(head_idx, span);
                        pop_owed    = 32'(hdr);
                        r.out_value = hdr;
                    end
                end
            end
            default:
            begin
                if (pop_owed == 0)
                    r.status = ST_NO_OPEN;
                else
                begin
                    r.out_value = ring_img[head_idx];
                    head_idx    = next_slot(head_idx, span);
                    pop_owed    = pop_owed - 1;
                    r.last      = (pop_owed == 0);
                end
            end
        endcase
        return r;
    endfunction

    // valid stays high across back-to-back words so it is never dropped and raised in one step
    task automatic send_word(input op_t op, input logic [BYTE_W-1:0] v, output ring_reply_t r);
        repeat (next_gap) @(posedge clk);
        cmd.valid     <= 1'b1;
        cmd.operation <= op;
        cmd.value     <= v;
        do
            @(posedge clk);
        while (!cmd.ready);
        r = apply_command(op, v);
        pending_replies.push_back(r);
        words_sent = words_sent + 1;
        next_gap   = draw_gap(cmd_calm);
        if (next_gap != 0)
            cmd.valid <= 1'b0;
    endtask

    task automatic set_ring_size(input logic [CFG_W-1:0] v);
        // valid is still high only when the last word had no gap after it
        if (next_gap == 0)
            cmd.valid <= 1'b0;
        wait (pending_replies.size() == 0);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        size_reg = v;
        clear_ring();
    endtask

    function automatic logic [BYTE_W-1:0] pick_length();
        int unsigned top;
        if ($urandom_range(0, 39) == 0)
            return 8'hFF;
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        top = span_now() / 3;
        if (top < 1)
            top = 1;
        if (top > 40)
            top = 40;
        return 8'($urandom_range(0, top));
    endfunction

    task automatic test_idle_replies();
        ring_reply_t r;
        send_word(OP_POP_HDR, 8'hFF, r);
        send_word(OP_POP_BYTE, 8'h00, r);
        send_word(OP_PUSH_BYTE, 8'h5A, r);
    endtask

    task automatic test_zero_length_record();
        ring_reply_t r;
        send_word(OP_PUSH_HDR, 8'h00, r);
        send_word(OP_POP_HDR, 8'hFF, r);
    endtask

    task automatic test_open_record_refusals();
        ring_reply_t r;
        send_word(OP_PUSH_HDR, 8'hFF, r);
        send_word(OP_PUSH_HDR, 8'h01, r);
        // header is there but its data is not
        send_word(OP_POP_HDR, 8'hFF, r);
        send_word(OP_PUSH_BYTE, 8'h00, r);
    endtask

    task automatic test_round_trip();
        ring_reply_t r;
        send_word(OP_PUSH_HDR, 8'h02, r);
        send_word(OP_PUSH_BYTE, 8'hFF, r);
        send_word(OP_PUSH_BYTE, 8'h00, r);
        // capacity below the stored length
        send_word(OP_POP_HDR, 8'h01, r);
        send_word(OP_PUSH_HDR, 8'h01, r);
        send_word(OP_PUSH_BYTE, 8'hAA, r);
        send_word(OP_POP_HDR, 8'h01, r);
        send_word(OP_POP_HDR, 8'hFF, r);
        send_word(OP_POP_BYTE, 8'h55, r);
    endtask

    task automatic test_tiny_rings();
        ring_reply_t r;
        set_ring_size(11'd0);
        send_word(OP_PUSH_HDR, 8'h01, r);
        send_word(OP_PUSH_HDR, 8'h00, r);
        send_word(OP_PUSH_HDR, 8'h00, r);
        send_word(OP_POP_HDR, 8'hFF, r);
        set_ring_size(11'd3);
        send_word(OP_PUSH_HDR, 8'h01, r);
        send_word(OP_PUSH_BYTE, 8'hC3, r);
        send_word(OP_POP_HDR, 8'hFF, r);
        send_word(OP_POP_BYTE, 8'h00, r);
    endtask

    // mostly whole records with random content, some cut short, some noise
    task automatic test_random_traffic(input int unsigned n_words);
        ring_reply_t       r;
        int unsigned       stop_at;
        int unsigned       pick;
        int unsigned       i;
        logic [BYTE_W-1:0] len;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                len = pick_length();
                send_word(OP_PUSH_HDR, len, r);
                if (r.status == ST_OK)
                begin
                    for (i = 0; i < 32'(len); i++)
                    begin
                        if ($urandom_range(0, 59) == 0)
                            break;
                        send_word(OP_PUSH_BYTE, 8'($urandom), r);
                    end
                end
            end
            else if (pick < 82)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_word(OP_POP_HDR, 8'($urandom), r);
                else
                    send_word(OP_POP_HDR, 8'hFF, r);
                if (r.status == ST_OK)
                begin
                    len = r.out_value;
                    for (i = 0; i < 32'(len); i++)
                    begin
                        if ($urandom_range(0, 59) == 0)
                            break;
                        send_word(OP_POP_BYTE, 8'($urandom), r);
                    end
                end
            end
            else
                send_word(op_t'($urandom_range(0, 3)), 8'($urandom), r);
        end
    endtask

    initial
    begin : reply_checker
        ring_reply_t want;
        int unsigned stall;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_gap(rsp_calm);
            if (stall != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
            if (pending_replies.size() == 0)
            begin
                $error("unexpected word: status %0d out_value %0d last %0d",
                       rsp.status, rsp.out_value, rsp.last);
                fail_count = fail_count + 1;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, rsp.status);
                    fail_count = fail_count + 1;
                end
                if (rsp.out_value !== want.out_value)
                begin
                    $error("out_value expected %0d actual %0d", want.out_value, rsp.out_value);
                    fail_count = fail_count + 1;
                end
                if (rsp.last !== want.last)
                begin
                    $error("last expected %0d actual %0d", want.last, rsp.last);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("length_prefixed_record_ring regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        cmd.valid     <= 1'b0;
        cmd.operation <= OP_PUSH_HDR;
        cmd.value     <= '0;
        quiet_cycles  = 0;
        words_sent    = 0;
        fail_count    = 0;
        next_gap      = 0;
        cmd_calm      = 1'b0;
        rsp_calm      = 1'b0;
        size_reg      = CFG_W'(SIZE_RESET);
        clear_ring();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_replies();
        test_zero_length_record();
        test_open_record_refusals();
        test_round_trip();
        test_tiny_rings();

        set_ring_size(11'h7FF);
        test_random_traffic(150);
        set_ring_size(11'($urandom_range(3, 40)));
        test_random_traffic(200);
        set_ring_size(11'($urandom_range(41, 400)));
        test_random_traffic(200);
        set_ring_size(11'd1);
        test_random_traffic(60);
        set_ring_size(11'($urandom_range(2, 1024)));
        test_random_traffic(150);
        set_ring_size(11'd1024);
        test_random_traffic(150);

        if (next_gap == 0)
            cmd.valid <= 1'b0;
        wait (pending_replies.size() == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("length_prefixed_record_ring regression: pass");
        else
            $display("length_prefixed_record_ring regression: fail");
        $finish;
    end

endmodule

### sim.f
rtl/core/lprr_pkg.sv
rtl/core/lprr_in_if.sv
rtl/core/lprr_out_if.sv
rtl/core/lprr_ram.sv
rtl/core/length_prefixed_record_ring.sv
sim/length_prefixed_record_ring_test.sv
